@@ rtl/core/evse_pkg.sv @@
package evse_pkg;

    localparam int MODE_W  = 2;
    localparam int CODE_W  = 4;
    localparam int STATE_W = 4;
    localparam int ERR_W   = 3;
    localparam int PILOT_W = 2;
    localparam int DUTY_W  = 10;
    localparam int PERM_W  = 2;
    localparam int CUR_W   = 10;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [STATE_W-1:0] {
        ST_DISABLED    = 4'd0,
        ST_IDLE        = 4'd1,
        ST_WAIT_AUTH   = 4'd2,
        ST_CHARGING    = 4'd3,
        ST_PAUSED_EV   = 4'd4,
        ST_PAUSED_EVSE = 4'd5,
        ST_FINISHED    = 4'd6,
        ST_ERROR       = 4'd7,
        ST_FAULTED     = 4'd8
    } sess_state_t;

    // control modes
    localparam logic [1:0] CM_NONE = 2'd0;
    localparam logic [1:0] CM_LOW  = 2'd1;
    localparam logic [1:0] CM_HIGH = 2'd2;

    // item kinds
    localparam logic [MODE_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [MODE_W-1:0] KIND_CMD   = 2'd2;

    // pilot events
    localparam logic [CODE_W-1:0] EV_PLUGGED   = 4'd0;
    localparam logic [CODE_W-1:0] EV_POWER_REQ = 4'd1;
    localparam logic [CODE_W-1:0] EV_STOP_REQ  = 4'd2;
    localparam logic [CODE_W-1:0] EV_UNPLUGGED = 4'd3;
    localparam logic [CODE_W-1:0] EV_ERR_FIRST = 4'd4;
    localparam logic [CODE_W-1:0] EV_ERR_LAST  = 4'd9;
    localparam logic [CODE_W-1:0] EV_ERR_BASE  = 4'd3;

    // host commands
    localparam logic [CODE_W-1:0] CMD_PAUSE      = 4'd0;
    localparam logic [CODE_W-1:0] CMD_RESUME     = 4'd1;
    localparam logic [CODE_W-1:0] CMD_ENABLE     = 4'd2;
    localparam logic [CODE_W-1:0] CMD_DISABLE    = 4'd3;
    localparam logic [CODE_W-1:0] CMD_RESTART    = 4'd4;
    localparam logic [CODE_W-1:0] CMD_AUTH_SET   = 4'd5;
    localparam logic [CODE_W-1:0] CMD_AUTH_CLEAR = 4'd6;

    localparam logic [PILOT_W-1:0] PILOT_NONE = 2'd0;
    localparam logic [PILOT_W-1:0] PILOT_HIGH = 2'd1;
    localparam logic [PILOT_W-1:0] PILOT_F    = 2'd2;
    localparam logic [PILOT_W-1:0] PILOT_PWM  = 2'd3;

    localparam logic [PERM_W-1:0] PERM_NONE   = 2'd0;
    localparam logic [PERM_W-1:0] PERM_FORBID = 2'd1;
    localparam logic [PERM_W-1:0] PERM_ALLOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOST_LINK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT = 1'b1;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1000;

    typedef struct packed {
        sess_state_t       st;
        logic [ERR_W-1:0]  err;
        logic              auth;
    } sess_t;

    typedef struct packed {
        sess_state_t         session_state;
        logic [ERR_W-1:0]    error_kind;
        logic [PILOT_W-1:0]  pilot_command;
        logic [DUTY_W-1:0]   duty;
        logic [PERM_W-1:0]   power_permission;
        logic                energy_reset;
        logic                event_forwarded;
        logic [CODE_W-1:0]   forwarded_code;
        logic                command_accepted;
    } result_t;

    // Duty in 0.1 % for an offered current in 0.1 A.
    // Divide by 3 and 5 through reciprocal multiply; exact over the value range.
    function automatic logic [DUTY_W-1:0] duty_of(input logic [CUR_W-1:0] c);
        logic [CUR_W-1:0] cl;
        logic [11:0]      five_c;
        logic [27:0]      p3;
        logic [10:0]      two_c;
        logic [28:0]      p5;
        logic [DUTY_W-1:0] d;
        cl     = (c > 10'd510) ? 10'd510 : c;
        five_c = {2'b00, cl} * 12'd5;
        p3     = {16'd0, five_c} * 28'd43691;
        two_c  = {c, 1'b0};
        p5     = {18'd0, two_c} * 29'd52429;
        if (c < 10'd59) begin
            d = DUTY_FULL;
        end else if (c <= 10'd61) begin
            d = 10'd100;
        end else if (c < 10'd525) begin
            d = p3[26:17];
        end else if (c <= 10'd800) begin
            d = p5[27:18] + 10'd640;
        end else if (c == 10'd801) begin
            d = 10'd970;
        end else begin
            d = DUTY_FULL;
        end
        return d;
    endfunction

endpackage

@@ rtl/core/evse_cfg.sv @@
module evse_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [evse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [evse_pkg::CUR_W-1:0]       cfg_data,
    output logic [1:0]                       host_link,
    output logic [evse_pkg::DUTY_W-1:0]      duty
);

    logic [1:0]                  host_link_reg;
    logic [1:0]                  host_link_next;
    logic [evse_pkg::DUTY_W-1:0] duty_reg;
    logic [evse_pkg::DUTY_W-1:0] duty_next;

    assign cfg_ready = 1'b1;

    // Keep only the PWM duty derived from max_current; recompute it on each max_current write.
    always_comb begin
        host_link_next = host_link_reg;
        duty_next      = duty_reg;
        if (cfg_valid) begin
            case (cfg_index)
                evse_pkg::CFG_HOST_LINK:   host_link_next = cfg_data[1:0];
                evse_pkg::CFG_MAX_CURRENT: duty_next = evse_pkg::duty_of(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_link_reg <= evse_pkg::CM_NONE;
            duty_reg      <= evse_pkg::DUTY_FULL;
        end else begin
            host_link_reg <= host_link_next;
            duty_reg      <= duty_next;
        end
    end

    assign host_link = host_link_reg;
    assign duty      = duty_reg;

endmodule

@@ rtl/core/evse_step.sv @@
module evse_step (
    input  evse_pkg::sess_t                  cur,
    input  logic [evse_pkg::MODE_W-1:0]      kind,
    input  logic [evse_pkg::CODE_W-1:0]      code,
    input  logic [1:0]                       host_link,
    input  logic [evse_pkg::DUTY_W-1:0]      duty,
    output evse_pkg::sess_t                  nxt,
    output evse_pkg::result_t                res
);

    logic                  active;
    logic                  high;
    evse_pkg::sess_state_t st_mid;

    assign active = (host_link == evse_pkg::CM_NONE) || (host_link == evse_pkg::CM_HIGH);
    assign high   = (host_link == evse_pkg::CM_HIGH);

    // next state
    always_comb begin
        nxt    = cur;
        st_mid = cur.st;
        case (kind)
            evse_pkg::KIND_TICK: begin
                if (active) begin
                    case (cur.st)
                        evse_pkg::ST_IDLE: begin
                            nxt.auth = 1'b0;
                        end
                        evse_pkg::ST_WAIT_AUTH: begin
                            if (host_link == evse_pkg::CM_NONE || cur.auth) begin
                                nxt.st = evse_pkg::ST_PAUSED_EV;
                            end
                        end
                        evse_pkg::ST_FINISHED: begin
                            if (host_link == evse_pkg::CM_NONE) begin
                                nxt.st = evse_pkg::ST_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            evse_pkg::KIND_EVENT: begin
                if (active) begin
                    // Unplug and errors override first, then the plug/pause moves.
                    if (code == evse_pkg::EV_UNPLUGGED) begin
                        st_mid = evse_pkg::ST_FINISHED;
                    end else if (code >= evse_pkg::EV_ERR_FIRST &&
                                 code <= evse_pkg::EV_ERR_LAST) begin
                        st_mid  = evse_pkg::ST_ERROR;
                        nxt.err = evse_pkg::ERR_W'(code - evse_pkg::EV_ERR_BASE);
                    end
                    nxt.st = st_mid;
                    if (st_mid == evse_pkg::ST_IDLE && code == evse_pkg::EV_PLUGGED) begin
                        nxt.st = evse_pkg::ST_WAIT_AUTH;
                    end else if (st_mid == evse_pkg::ST_CHARGING &&
                                 code == evse_pkg::EV_STOP_REQ) begin
                        nxt.st = evse_pkg::ST_PAUSED_EV;
                    end else if (st_mid == evse_pkg::ST_PAUSED_EV &&
                                 code == evse_pkg::EV_POWER_REQ) begin
                        nxt.st = evse_pkg::ST_CHARGING;
                    end
                end
            end
            evse_pkg::KIND_CMD: begin
                case (code)
                    evse_pkg::CMD_PAUSE: begin
                        if (high && cur.st == evse_pkg::ST_CHARGING) begin
                            nxt.st = evse_pkg::ST_PAUSED_EVSE;
                        end
                    end
                    evse_pkg::CMD_RESUME: begin
                        if (high && cur.st == evse_pkg::ST_PAUSED_EVSE) begin
                            nxt.st = evse_pkg::ST_CHARGING;
                        end
                    end
                    evse_pkg::CMD_ENABLE: begin
                        if (cur.st == evse_pkg::ST_DISABLED) begin
                            nxt.st = evse_pkg::ST_IDLE;
                        end
                    end
                    evse_pkg::CMD_DISABLE: begin
                        nxt.st = evse_pkg::ST_DISABLED;
                    end
                    evse_pkg::CMD_RESTART: begin
                        if (high && cur.st == evse_pkg::ST_FINISHED) begin
                            nxt.st = evse_pkg::ST_IDLE;
                        end
                    end
                    evse_pkg::CMD_AUTH_SET: begin
                        nxt.auth = 1'b1;
                    end
                    evse_pkg::CMD_AUTH_CLEAR: begin
                        nxt.auth = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        res = '0;
        case (kind)
            evse_pkg::KIND_TICK: begin
                if (active) begin
                    case (cur.st)
                        evse_pkg::ST_DISABLED,
                        evse_pkg::ST_FAULTED,
                        evse_pkg::ST_FINISHED: begin
                            res.pilot_command = evse_pkg::PILOT_F;
                        end
                        evse_pkg::ST_IDLE: begin
                            res.pilot_command = evse_pkg::PILOT_HIGH;
                            res.energy_reset  = 1'b1;
                        end
                        evse_pkg::ST_WAIT_AUTH: begin
                            res.power_permission = evse_pkg::PERM_FORBID;
                        end
                        evse_pkg::ST_CHARGING,
                        evse_pkg::ST_PAUSED_EV: begin
                            res.pilot_command    = evse_pkg::PILOT_PWM;
                            res.duty             = duty;
                            res.power_permission = evse_pkg::PERM_ALLOW;
                        end
                        evse_pkg::ST_PAUSED_EVSE,
                        evse_pkg::ST_ERROR: begin
                            res.pilot_command = evse_pkg::PILOT_HIGH;
                        end
                        default: ;
                    endcase
                end
            end
            evse_pkg::KIND_EVENT: begin
                if (!active) begin
                    res.event_forwarded = 1'b1;
                    res.forwarded_code  = code;
                end
            end
            evse_pkg::KIND_CMD: begin
                case (code)
                    evse_pkg::CMD_PAUSE: begin
                        res.command_accepted = high && cur.st == evse_pkg::ST_CHARGING;
                    end
                    evse_pkg::CMD_RESUME: begin
                        res.command_accepted = high && cur.st == evse_pkg::ST_PAUSED_EVSE;
                    end
                    evse_pkg::CMD_ENABLE: begin
                        res.command_accepted = (cur.st == evse_pkg::ST_DISABLED);
                    end
                    evse_pkg::CMD_RESTART: begin
                        res.command_accepted = high && cur.st == evse_pkg::ST_FINISHED;
                    end
                    evse_pkg::CMD_DISABLE,
                    evse_pkg::CMD_AUTH_SET,
                    evse_pkg::CMD_AUTH_CLEAR: begin
                        res.command_accepted = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.session_state = nxt.st;
        res.error_kind    = nxt.err;
    end

endmodule

@@ rtl/core/evse_charge_session_controller_top.sv @@
// Charge session controller: input register, one step of logic, result register.
// A transferred item waits in the input register and moves into the result register
// when that register is free or drains; its result is offered on the m_ channel at once.
// Throughput: one item per cycle while m_ready holds; the session state is updated
// as an item moves into the result register, so the next item sees it at once.
// Reset (aresetn low, synchronous): state disabled, no error, not authorized,
// control mode none, max current 0, both channels empty.
module evse_charge_session_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [evse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evse_pkg::CUR_W-1:0]        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [evse_pkg::MODE_W-1:0]       s_mode,
    input  logic [evse_pkg::CODE_W-1:0]       s_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [evse_pkg::STATE_W-1:0]      m_session_state,
    output logic [evse_pkg::ERR_W-1:0]        m_error_kind,
    output logic [evse_pkg::PILOT_W-1:0]      m_pilot_command,
    output logic [evse_pkg::DUTY_W-1:0]       m_duty_tenths_percent,
    output logic [evse_pkg::PERM_W-1:0]       m_power_permission,
    output logic                              m_energy_reset,
    output logic                              m_event_forwarded,
    output logic [evse_pkg::CODE_W-1:0]       m_forwarded_code,
    output logic                              m_command_accepted
);

    logic [1:0]                  host_link;
    logic [evse_pkg::DUTY_W-1:0] duty;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [evse_pkg::MODE_W-1:0] kind_reg;
    logic [evse_pkg::CODE_W-1:0] code_reg;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    evse_pkg::result_t           res_reg;
    evse_pkg::result_t           res_next;
    evse_pkg::sess_t             sess_reg;
    evse_pkg::sess_t             sess_next;
    logic                        advance;
    logic                        in_xfer;

    evse_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .host_link    (host_link),
        .duty         (duty)
    );

    evse_step u_step (
        .cur          (sess_reg),
        .kind         (kind_reg),
        .code         (code_reg),
        .host_link    (host_link),
        .duty         (duty),
        .nxt          (sess_next),
        .res          (res_next)
    );

    // Advance the held item whenever the result register is free or drains now.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            sess_reg     <= '{st: evse_pkg::ST_DISABLED, err: '0, auth: 1'b0};
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                sess_reg <= sess_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg <= s_mode;
            code_reg <= s_code;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_session_state       = res_reg.session_state;
    assign m_error_kind          = res_reg.error_kind;
    assign m_pilot_command       = res_reg.pilot_command;
    assign m_duty_tenths_percent = res_reg.duty;
    assign m_power_permission    = res_reg.power_permission;
    assign m_energy_reset        = res_reg.energy_reset;
    assign m_event_forwarded     = res_reg.event_forwarded;
    assign m_forwarded_code      = res_reg.forwarded_code;
    assign m_command_accepted    = res_reg.command_accepted;

`ifndef SYNTHESIS
    a_duty_only_pwm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pilot_command != evse_pkg::PILOT_PWM |-> m_duty_tenths_percent == '0)
        else $error("duty set without PWM pilot");

    a_allow_with_pwm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_power_permission == evse_pkg::PERM_ALLOW
        |-> m_pilot_command == evse_pkg::PILOT_PWM)
        else $error("power allowed without PWM pilot");

    a_energy_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_energy_reset |-> m_session_state == evse_pkg::ST_IDLE)
        else $error("energy reset outside idle");

    a_forward_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_forwarded
        |-> !m_command_accepted && m_pilot_command == evse_pkg::PILOT_NONE)
        else $error("forwarded event with other action");

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(kind_reg) && $stable(code_reg))
        else $error("stalled item lost");
`endif

endmodule

@@ test/evse_charge_session_controller_top_tb.sv @@
module evse_charge_session_controller_top_tb;

    import evse_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam logic [1:0] CM_SPARE = 2'd3;
    localparam logic [MODE_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [CODE_W-1:0] CODE_TOP = 4'hF;

    typedef struct packed {
        logic [MODE_W-1:0] kind;
        logic [CODE_W-1:0] code;
    } session_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CUR_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode = '0;
    logic [CODE_W-1:0]    s_code = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [STATE_W-1:0]   m_session_state;
    logic [ERR_W-1:0]     m_error_kind;
    logic [PILOT_W-1:0]   m_pilot_command;
    logic [DUTY_W-1:0]    m_duty_tenths_percent;
    logic [PERM_W-1:0]    m_power_permission;
    logic                 m_energy_reset;
    logic                 m_event_forwarded;
    logic [CODE_W-1:0]    m_forwarded_code;
    logic                 m_command_accepted;

    // shadow of the session and its configuration
    sess_state_t          sess_st = ST_DISABLED;
    logic [ERR_W-1:0]     err_kind = '0;
    logic                 auth_flag = 1'b0;
    logic [1:0]           ctl_mode = CM_NONE;
    logic [CUR_W-1:0]     max_cur = '0;

    session_item_t        session_items[$];
    result_t              due_reports[$];
    result_t              seen_report;
    result_t              want_report;
    int unsigned          report_count = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          queued = 0;
    int unsigned          cycle_count = 0;
    logic                 item_taken = 1'b0;
    logic                 steady = 1'b0;
    int unsigned          in_gap = 0;
    int unsigned          out_hold = 0;

    evse_charge_session_controller_top dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_mode                (s_mode),
        .s_code                (s_code),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_session_state       (m_session_state),
        .m_error_kind          (m_error_kind),
        .m_pilot_command       (m_pilot_command),
        .m_duty_tenths_percent (m_duty_tenths_percent),
        .m_power_permission    (m_power_permission),
        .m_energy_reset        (m_energy_reset),
        .m_event_forwarded     (m_event_forwarded),
        .m_forwarded_code      (m_forwarded_code),
        .m_command_accepted    (m_command_accepted)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    function automatic logic [DUTY_W-1:0] pilot_duty(input logic [CUR_W-1:0] amps);
        int unsigned a;
        a = amps;
        if (a < 59) return DUTY_FULL;
        if (a <= 61) return 10'd100;
        if (a < 525) begin
            // clamp to the 51 A ceiling of the low band
            if (a > 510) a = 510;
            return DUTY_W'(a * 5 / 3);
        end
        if (a <= 800) return DUTY_W'(a * 2 / 5 + 640);
        if (a == 801) return 10'd970;
        return DUTY_FULL;
    endfunction

    function automatic result_t advance_session(input logic [MODE_W-1:0] kind,
                                                input logic [CODE_W-1:0] code);
        result_t r;
        logic    active;
        logic    high;
        r = '0;
        active = (ctl_mode == CM_NONE) || (ctl_mode == CM_HIGH);
        high = (ctl_mode == CM_HIGH);
        case (kind)
            KIND_TICK: begin
                if (active) begin
                    case (sess_st)
                        ST_DISABLED, ST_FAULTED: r.pilot_command = PILOT_F;
                        ST_IDLE: begin
                            r.pilot_command = PILOT_HIGH;
                            r.energy_reset = 1'b1;
                            auth_flag = 1'b0;
                        end
                        ST_WAIT_AUTH: begin
                            r.power_permission = PERM_FORBID;
                            if (ctl_mode == CM_NONE || auth_flag) sess_st = ST_PAUSED_EV;
                        end
                        ST_CHARGING, ST_PAUSED_EV: begin
                            r.pilot_command = PILOT_PWM;
                            r.duty = pilot_duty(max_cur);
                            r.power_permission = PERM_ALLOW;
                        end
                        ST_PAUSED_EVSE, ST_ERROR: r.pilot_command = PILOT_HIGH;
                        ST_FINISHED: begin
                            if (ctl_mode == CM_NONE) sess_st = ST_IDLE;
                            r.pilot_command = PILOT_F;
                        end
                        default: ;
                    endcase
                end
            end
            KIND_EVENT: begin
                if (!active) begin
                    r.event_forwarded = 1'b1;
                    r.forwarded_code = code;
                end else begin
                    if (code == EV_UNPLUGGED) begin
                        sess_st = ST_FINISHED;
                    end else if (code >= EV_ERR_FIRST && code <= EV_ERR_LAST) begin
                        sess_st = ST_ERROR;
                        err_kind = ERR_W'(code - EV_ERR_BASE);
                    end
                    if (sess_st == ST_IDLE && code == EV_PLUGGED) begin
                        sess_st = ST_WAIT_AUTH;
                    end else if (sess_st == ST_CHARGING && code == EV_STOP_REQ) begin
                        sess_st = ST_PAUSED_EV;
                    end else if (sess_st == ST_PAUSED_EV && code == EV_POWER_REQ) begin
                        sess_st = ST_CHARGING;
                    end
                end
            end
            KIND_CMD: begin
                case (code)
                    CMD_PAUSE: begin
                        if (high && sess_st == ST_CHARGING) begin
                            sess_st = ST_PAUSED_EVSE;
                            r.command_accepted = 1'b1;
                        end
                    end
                    CMD_RESUME: begin
                        if (high && sess_st == ST_PAUSED_EVSE) begin
                            sess_st = ST_CHARGING;
                            r.command_accepted = 1'b1;
                        end
                    end
                    CMD_ENABLE: begin
                        if (sess_st == ST_DISABLED) begin
                            sess_st = ST_IDLE;
                            r.command_accepted = 1'b1;
                        end
                    end
                    CMD_DISABLE: begin
                        sess_st = ST_DISABLED;
                        r.command_accepted = 1'b1;
                    end
                    CMD_RESTART: begin
                        if (high && sess_st == ST_FINISHED) begin
                            sess_st = ST_IDLE;
                            r.command_accepted = 1'b1;
                        end
                    end
                    CMD_AUTH_SET: begin
                        auth_flag = 1'b1;
                        r.command_accepted = 1'b1;
                    end
                    CMD_AUTH_CLEAR: begin
                        auth_flag = 1'b0;
                        r.command_accepted = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.session_state = sess_st;
        r.error_kind = err_kind;
        return r;
    endfunction

    function automatic string fmt_report(input result_t r);
        return $sformatf("st=%0d err=%0d pilot=%0d duty=%0d perm=%0d erst=%0d fwd=%0d/%0d acc=%0d",
                         r.session_state, r.error_kind, r.pilot_command, r.duty,
                         r.power_permission, r.energy_reset, r.event_forwarded,
                         r.forwarded_code, r.command_accepted);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // monitor: track register writes, predict on input transfer, check on output transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HOST_LINK) ctl_mode = cfg_data[1:0];
                else max_cur = cfg_data;
            end
            if (s_valid && s_ready) due_reports.push_back(advance_session(s_mode, s_code));
            if (m_valid && m_ready) begin
                seen_report.session_state = sess_state_t'(m_session_state);
                seen_report.error_kind = m_error_kind;
                seen_report.pilot_command = m_pilot_command;
                seen_report.duty = m_duty_tenths_percent;
                seen_report.power_permission = m_power_permission;
                seen_report.energy_reset = m_energy_reset;
                seen_report.event_forwarded = m_event_forwarded;
                seen_report.forwarded_code = m_forwarded_code;
                seen_report.command_accepted = m_command_accepted;
                if (due_reports.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("report %0d arrived with nothing pending: %s",
                                 report_count, fmt_report(seen_report));
                end else begin
                    want_report = due_reports.pop_front();
                    if (seen_report !== want_report) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("report %0d mismatch: expected %s, got %s", report_count,
                                     fmt_report(want_report), fmt_report(seen_report));
                    end
                end
                report_count = report_count + 1;
            end
        end
        item_taken <= aresetn && s_valid && s_ready;
    end

    // item driver
    always @(negedge aclk) begin
        if (s_valid && !item_taken) begin
            // hold until the transfer
        end else if (in_gap != 0) begin
            s_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (!steady && $urandom_range(7) == 0) begin
            s_valid <= 1'b0;
            in_gap <= $urandom_range(2);
        end else if (session_items.size() != 0) begin
            s_valid <= 1'b1;
            {s_mode, s_code} <= session_items.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge aclk) begin
        if (out_hold != 0) begin
            m_ready <= 1'b0;
            out_hold <= out_hold - 1;
        end else if (!steady && $urandom_range(7) == 0) begin
            m_ready <= 1'b0;
            out_hold <= $urandom_range(2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CUR_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(input logic [MODE_W-1:0] kind, input logic [CODE_W-1:0] code);
        session_item_t it;
        it.kind = kind;
        it.code = code;
        session_items.push_back(it);
        queued = queued + 1;
    endtask

    // mix in stray items and the odd corrupted code
    task automatic queue_noisy(input logic [MODE_W-1:0] kind, input logic [CODE_W-1:0] code);
        if ($urandom_range(7) == 0)
            queue_item(MODE_W'($urandom_range(3)), CODE_W'($urandom_range(15)));
        if ($urandom_range(15) == 0) queue_item(kind, CODE_W'($urandom_range(15)));
        else queue_item(kind, code);
    endtask

    task automatic queue_tick();
        queue_noisy(KIND_TICK, CODE_W'($urandom_range(15)));
    endtask

    task automatic queue_session();
        int unsigned steps;
        if ($urandom_range(1) == 1) queue_noisy(KIND_CMD, CMD_DISABLE);
        queue_noisy(KIND_CMD, CMD_ENABLE);
        queue_tick();
        queue_noisy(KIND_EVENT, EV_PLUGGED);
        if ($urandom_range(3) != 0) queue_noisy(KIND_CMD, CMD_AUTH_SET);
        queue_tick();
        queue_noisy(KIND_EVENT, EV_POWER_REQ);
        steps = $urandom_range(1, 8);
        repeat (steps) begin
            case ($urandom_range(5))
                0, 1: queue_tick();
                2: queue_noisy(KIND_EVENT, EV_STOP_REQ);
                3: queue_noisy(KIND_EVENT, EV_POWER_REQ);
                4: queue_noisy(KIND_CMD, CMD_PAUSE);
                default: queue_noisy(KIND_CMD, CMD_RESUME);
            endcase
        end
        case ($urandom_range(3))
            0, 1: queue_noisy(KIND_EVENT, EV_UNPLUGGED);
            2: queue_noisy(KIND_EVENT, CODE_W'($urandom_range(EV_ERR_FIRST, EV_ERR_LAST)));
            default: queue_noisy(KIND_CMD, CMD_DISABLE);
        endcase
        queue_tick();
        if ($urandom_range(3) == 0) queue_noisy(KIND_CMD, CMD_AUTH_CLEAR);
        queue_noisy(KIND_CMD, CMD_RESTART);
        queue_tick();
    endtask

    task automatic drain();
        while (session_items.size() != 0 || s_valid || due_reports.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [1:0] cm, input logic [CUR_W-1:0] cur,
                             input int unsigned n, input logic calm);
        drain();
        steady = calm;
        write_reg(CFG_HOST_LINK, CUR_W'(cm));
        write_reg(CFG_MAX_CURRENT, cur);
        queued = 0;
        while (queued < n) queue_session();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("evse_charge_session_controller_top regression: fail");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_HOST_LINK, CUR_W'(CM_NONE));
        write_reg(CFG_MAX_CURRENT, '0);
        queue_item(KIND_TICK, CODE_TOP);
        queue_item(KIND_CMD, CMD_PAUSE);
        queue_item(KIND_CMD, CMD_ENABLE);
        queue_item(KIND_CMD, CMD_ENABLE);
        queue_item(KIND_TICK, '0);
        queue_item(KIND_EVENT, EV_PLUGGED);
        queue_item(KIND_TICK, '0);
        queue_item(KIND_TICK, '0);
        queue_item(KIND_EVENT, EV_POWER_REQ);
        queue_item(KIND_EVENT, EV_STOP_REQ);
        queue_item(KIND_EVENT, EV_POWER_REQ);
        queue_item(KIND_EVENT, CODE_TOP);
        queue_item(KIND_CMD, CODE_TOP);
        queue_item(KIND_SPARE, CODE_TOP);
        queue_item(KIND_EVENT, EV_UNPLUGGED);
        queue_item(KIND_TICK, '0);
        queue_item(KIND_EVENT, EV_PLUGGED);
        queue_item(KIND_EVENT, EV_ERR_FIRST);
        queue_item(KIND_TICK, '0);
        queue_item(KIND_EVENT, EV_ERR_LAST);
        queue_item(KIND_CMD, CMD_AUTH_SET);
        queue_item(KIND_CMD, CMD_AUTH_CLEAR);
        queue_item(KIND_CMD, CMD_RESTART);
        queue_item(KIND_CMD, CMD_DISABLE);

        run_phase(CM_HIGH, 10'd800, 150, 1'b0);
        run_phase(CM_NONE, 10'd58, 120, 1'b0);
        run_phase(CM_HIGH, 10'd59, 120, 1'b1);
        run_phase(CM_LOW, 10'd300, 100, 1'b0);
        run_phase(CM_NONE, 10'd61, 100, 1'b0);
        run_phase(CM_HIGH, 10'd62, 120, 1'b0);
        run_phase(CM_NONE, 10'd510, 100, 1'b1);
        run_phase(CM_HIGH, 10'd511, 100, 1'b0);
        run_phase(CM_SPARE, 10'd524, 80, 1'b0);
        run_phase(CM_HIGH, 10'd525, 120, 1'b0);
        run_phase(CM_NONE, 10'd801, 100, 1'b0);
        run_phase(CM_HIGH, 10'd1023, 100, 1'b0);
        run_phase(CM_NONE, CUR_W'($urandom_range(800)), 120, 1'b0);
        run_phase(CM_HIGH, CUR_W'($urandom_range(800)), 150, 1'b1);
        drain();

        if (mismatch_count == 0) begin
            $display("evse_charge_session_controller_top regression: pass");
        end else begin
            $display("evse_charge_session_controller_top regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/evse_pkg.sv
rtl/core/evse_cfg.sv
rtl/core/evse_step.sv
rtl/core/evse_charge_session_controller_top.sv
test/evse_charge_session_controller_top_tb.sv
